FILE: sv/bkpc_pkg.sv
// ----------------------------------------------------------------------------
// bkpc_pkg
// Shared types, format codes, register map and pixel codec functions of the
// bilinear keyed pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package bkpc_pkg;

  localparam logic [2:0] FMT_GREY8    = 3'd2;
  localparam logic [2:0] FMT_ARGB1555 = 3'd3;
  localparam logic [2:0] FMT_RGB565   = 3'd4;
  localparam logic [2:0] FMT_RGB888   = 3'd5;
  localparam logic [2:0] FMT_ARGB8888 = 3'd6;

  localparam logic [2:0] REG_SOURCE_FORMAT = 3'd0;
  localparam logic [2:0] REG_DEST_FORMAT   = 3'd1;
  localparam logic [2:0] REG_KEY_ENABLE    = 3'd2;
  localparam logic [2:0] REG_KEY_COLOR     = 3'd3;
  localparam logic [2:0] REG_KEY_MASK      = 3'd4;

  localparam int unsigned APB_ADDR_W = 5;

  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;

  localparam logic [8:0]  WEIGHT_ONE = 9'd256;
  localparam logic [23:0] RGB_ALL    = 24'hffffff;

  typedef struct packed {
    logic [2:0]  source_format;
    logic [2:0]  dest_format;
    logic        key_enable;
    logic [23:0] key_color;
    logic [23:0] key_mask;
  } cfg_t;

  typedef logic [3:0][31:0] quad_t;

  function automatic logic fmt_known(logic [2:0] f);
    return (f >= FMT_GREY8) && (f <= FMT_ARGB8888);
  endfunction

  function automatic logic [7:0] widen5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [31:0] decode_texel(logic [2:0] f, logic [31:0] raw);
    logic [31:0] res;
    case (f)
      FMT_GREY8:    res = {8'hff, raw[7:0], raw[7:0], raw[7:0]};
      FMT_ARGB1555: res = {8'hff, widen5(raw[14:10]), widen5(raw[9:5]), widen5(raw[4:0])};
      FMT_RGB565:   res = {8'hff, widen5(raw[15:11]), widen6(raw[10:5]), widen5(raw[4:0])};
      FMT_RGB888:   res = {8'hff, raw[23:0]};
      default:      res = raw;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] encode_pixel(logic [2:0] f, logic [31:0] argb);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] luma;
    logic [31:0] res;
    r    = argb[23:16];
    g    = argb[15:8];
    b    = argb[7:0];
    luma = 16'(r) * LUMA_R + 16'(g) * LUMA_G + 16'(b) * LUMA_B;
    case (f)
      FMT_GREY8:    res = {24'd0, luma[15:8]};
      FMT_ARGB1555: res = {16'd0, 1'b1, r[7:3], g[7:3], b[7:3]};
      FMT_RGB565:   res = {16'd0, r[7:3], g[7:2], b[7:3]};
      FMT_RGB888:   res = {8'd0, argb[23:0]};
      default:      res = argb;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/bkpc_texel_if.sv
// ----------------------------------------------------------------------------
// bkpc_texel_if
// Request channel: four raw source texels and the x/y blend weights.
// ----------------------------------------------------------------------------
`default_nettype none

interface bkpc_texel_if;
  logic        valid;
  logic        ready;
  logic [31:0] texel_top_left;
  logic [31:0] texel_top_right;
  logic [31:0] texel_bottom_left;
  logic [31:0] texel_bottom_right;
  logic [7:0]  frac_x;
  logic [7:0]  frac_y;

  modport source (
    output valid, texel_top_left, texel_top_right, texel_bottom_left,
           texel_bottom_right, frac_x, frac_y,
    input  ready
  );
  modport sink (
    input  valid, texel_top_left, texel_top_right, texel_bottom_left,
           texel_bottom_right, frac_x, frac_y,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/bkpc_pixel_if.sv
// ----------------------------------------------------------------------------
// bkpc_pixel_if
// Result channel: encoded pixel, write enable and blended ARGB colour.
// ----------------------------------------------------------------------------
`default_nettype none

interface bkpc_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        write_enable;
  logic [31:0] color_argb;

  modport source (
    output valid, pixel_out, write_enable, color_argb,
    input  ready
  );
  modport sink (
    input  valid, pixel_out, write_enable, color_argb,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/bkpc_regs.sv
// ----------------------------------------------------------------------------
// bkpc_regs
// APB configuration registers: formats and colour key.
// ----------------------------------------------------------------------------
`default_nettype none

module bkpc_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bkpc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output bkpc_pkg::cfg_t                       cfg_o
);

  bkpc_pkg::cfg_t cfg_q;
  bkpc_pkg::cfg_t cfg_d;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[bkpc_pkg::APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        bkpc_pkg::REG_SOURCE_FORMAT: cfg_d.source_format = pwdata[2:0];
        bkpc_pkg::REG_DEST_FORMAT:   cfg_d.dest_format   = pwdata[2:0];
        bkpc_pkg::REG_KEY_ENABLE:    cfg_d.key_enable    = pwdata[0];
        bkpc_pkg::REG_KEY_COLOR:     cfg_d.key_color     = pwdata[23:0];
        bkpc_pkg::REG_KEY_MASK:      cfg_d.key_mask      = pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bkpc_pkg::REG_SOURCE_FORMAT: prdata = {29'd0, cfg_q.source_format};
      bkpc_pkg::REG_DEST_FORMAT:   prdata = {29'd0, cfg_q.dest_format};
      bkpc_pkg::REG_KEY_ENABLE:    prdata = {31'd0, cfg_q.key_enable};
      bkpc_pkg::REG_KEY_COLOR:     prdata = {8'd0, cfg_q.key_color};
      bkpc_pkg::REG_KEY_MASK:      prdata = {8'd0, cfg_q.key_mask};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_format <= bkpc_pkg::FMT_ARGB8888;
      cfg_q.dest_format   <= bkpc_pkg::FMT_ARGB8888;
      cfg_q.key_enable    <= 1'b0;
      cfg_q.key_color     <= 24'd0;
      cfg_q.key_mask      <= bkpc_pkg::RGB_ALL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bkpc_decode.sv
// ----------------------------------------------------------------------------
// bkpc_decode
// Stage 1: unpack the four source texels to ARGB8888.
// ----------------------------------------------------------------------------
`default_nettype none

module bkpc_decode (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [2:0]      source_format_i,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire bkpc_pkg::quad_t texel_i,
  input  wire logic [7:0]      frac_x_i,
  input  wire logic [7:0]      frac_y_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output bkpc_pkg::quad_t      argb_o,
  output logic      [7:0]      frac_x_o,
  output logic      [7:0]      frac_y_o
);

  logic            valid_q;
  bkpc_pkg::quad_t argb_q;
  bkpc_pkg::quad_t argb_d;
  logic [7:0]      fx_q;
  logic [7:0]      fy_q;

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign argb_o   = argb_q;
  assign frac_x_o = fx_q;
  assign frac_y_o = fy_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      argb_d[i] = bkpc_pkg::decode_texel(source_format_i, texel_i[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      argb_q <= argb_d;
      fx_q   <= frac_x_i;
      fy_q   <= frac_y_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bkpc_lerp.sv
// ----------------------------------------------------------------------------
// bkpc_lerp
// Stages 2 and 3: horizontal blend of both rows, then vertical blend.
// ----------------------------------------------------------------------------
`default_nettype none

module bkpc_lerp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire bkpc_pkg::quad_t argb_i,
  input  wire logic [7:0]      frac_x_i,
  input  wire logic [7:0]      frac_y_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output logic      [31:0]     argb_o
);

  // argb_i order: top left, top right, bottom left, bottom right
  logic             h_valid_q;
  logic             h_ready;
  logic [3:0][15:0] top_q;
  logic [3:0][15:0] bot_q;
  logic [3:0][15:0] top_d;
  logic [3:0][15:0] bot_d;
  logic [7:0]       fy_q;
  logic             v_valid_q;
  logic [31:0]      argb_q;
  logic [31:0]      argb_d;
  logic [8:0]       wx_l;
  logic [8:0]       wx_r;
  logic [8:0]       wy_t;
  logic [8:0]       wy_b;

  assign wx_r = {1'b0, frac_x_i};
  assign wx_l = bkpc_pkg::WEIGHT_ONE - wx_r;
  assign wy_b = {1'b0, fy_q};
  assign wy_t = bkpc_pkg::WEIGHT_ONE - wy_b;

  assign ready_o = !h_valid_q || h_ready;
  assign h_ready = !v_valid_q || ready_i;
  assign valid_o = v_valid_q;
  assign argb_o  = argb_q;

  always_comb begin
    logic [16:0] t;
    logic [16:0] b;
    for (int c = 0; c < 4; c++) begin
      t = 17'(argb_i[0][c*8 +: 8]) * 17'(wx_l) + 17'(argb_i[1][c*8 +: 8]) * 17'(wx_r);
      b = 17'(argb_i[2][c*8 +: 8]) * 17'(wx_l) + 17'(argb_i[3][c*8 +: 8]) * 17'(wx_r);
      top_d[c] = t[15:0];
      bot_d[c] = b[15:0];
    end
  end

  always_comb begin
    logic [24:0] v;
    for (int c = 0; c < 4; c++) begin
      v = 25'(top_q[c]) * 25'(wy_t) + 25'(bot_q[c]) * 25'(wy_b);
      argb_d[c*8 +: 8] = v[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
      v_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        h_valid_q <= valid_i;
      end
      if (h_ready) begin
        v_valid_q <= h_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      top_q <= top_d;
      bot_q <= bot_d;
      fy_q  <= frac_y_i;
    end
    if (h_ready && h_valid_q) begin
      argb_q <= argb_d;
    end
  end

  a_v_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_valid_q && !ready_i |=> v_valid_q && $stable(argb_q))
    else $error("vertical stage lost a stalled request");

  a_h_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_valid_q && !h_ready |=> h_valid_q && $stable(top_q) && $stable(bot_q))
    else $error("horizontal stage lost a stalled request");

endmodule

`default_nettype wire

FILE: sv/bkpc_encode.sv
// ----------------------------------------------------------------------------
// bkpc_encode
// Stage 4: colour-key test and destination encoding into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bkpc_encode (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bkpc_pkg::cfg_t cfg_i,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire logic [31:0]    argb_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output logic      [31:0]    pixel_o,
  output logic                write_enable_o,
  output logic      [31:0]    color_o
);

  logic        valid_q;
  logic [31:0] pixel_q;
  logic [31:0] pixel_d;
  logic        we_q;
  logic        we_d;
  logic [31:0] color_q;
  logic [31:0] color_d;
  logic [23:0] msk;
  logic        key_hit;
  logic        known;

  assign ready_o        = !valid_q || ready_i;
  assign valid_o        = valid_q;
  assign pixel_o        = pixel_q;
  assign write_enable_o = we_q;
  assign color_o        = color_q;

  assign known   = bkpc_pkg::fmt_known(cfg_i.source_format)
                && bkpc_pkg::fmt_known(cfg_i.dest_format);
  assign msk     = (cfg_i.key_mask == 24'd0) ? bkpc_pkg::RGB_ALL : cfg_i.key_mask;
  assign key_hit = cfg_i.key_enable && ((argb_i[23:0] & msk) == (cfg_i.key_color & msk));

  always_comb begin
    if (known) begin
      pixel_d = bkpc_pkg::encode_pixel(cfg_i.dest_format, argb_i);
      we_d    = !key_hit;
      color_d = argb_i;
    end else begin
      pixel_d = 32'd0;
      we_d    = 1'b0;
      color_d = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pixel_q <= pixel_d;
      we_q    <= we_d;
      color_q <= color_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bilinear_keyed_pixel_converter_unit.sv
// Requests pass four register stages (decode, horizontal blend, vertical
// blend, key/encode) on their way to dst_o, each freeing as soon as its data
// moves on. Throughput: one request per cycle while dst_o does not stall.
// Reset: stage valids cleared, registers back to ARGB8888 in and out, key off.
// ----------------------------------------------------------------------------
// bilinear_keyed_pixel_converter_unit
// Bilinear texel filter with source decode, colour key and destination encode.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_keyed_pixel_converter_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bkpc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  bkpc_texel_if.sink                           src_i,
  bkpc_pixel_if.source                         dst_o
);

  bkpc_pkg::cfg_t  cfg;
  bkpc_pkg::quad_t texels;
  bkpc_pkg::quad_t dec_argb;
  logic            dec_valid;
  logic            dec_ready;
  logic [7:0]      dec_fx;
  logic [7:0]      dec_fy;
  logic            blend_valid;
  logic            blend_ready;
  logic [31:0]     blend_argb;

  assign texels = {src_i.texel_bottom_right, src_i.texel_bottom_left,
                   src_i.texel_top_right, src_i.texel_top_left};

  bkpc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bkpc_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .source_format_i (cfg.source_format),
    .valid_i         (src_i.valid),
    .ready_o         (src_i.ready),
    .texel_i         (texels),
    .frac_x_i        (src_i.frac_x),
    .frac_y_i        (src_i.frac_y),
    .valid_o         (dec_valid),
    .ready_i         (dec_ready),
    .argb_o          (dec_argb),
    .frac_x_o        (dec_fx),
    .frac_y_o        (dec_fy)
  );

  bkpc_lerp u_lerp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dec_valid),
    .ready_o  (dec_ready),
    .argb_i   (dec_argb),
    .frac_x_i (dec_fx),
    .frac_y_i (dec_fy),
    .valid_o  (blend_valid),
    .ready_i  (blend_ready),
    .argb_o   (blend_argb)
  );

  bkpc_encode u_encode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .valid_i        (blend_valid),
    .ready_o        (blend_ready),
    .argb_i         (blend_argb),
    .valid_o        (dst_o.valid),
    .ready_i        (dst_o.ready),
    .pixel_o        (dst_o.pixel_out),
    .write_enable_o (dst_o.write_enable),
    .color_o        (dst_o.color_argb)
  );

  a_req_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_i.valid && src_i.ready |=> dec_valid)
    else $error("accepted request missing from decode stage");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !src_i.ready |-> dst_o.valid && !dst_o.ready)
    else $error("request refused while pipeline has a bubble");

endmodule

`default_nettype wire
